// File: src/mlrp_pkg.sv
// ----------------------------------------------------------------------------
// mlrp_pkg
// Types and constants of the mip level residency policy block: payload
// structs, op codes, configuration register indexes and status codes.
// ----------------------------------------------------------------------------
package mlrp_pkg;

    localparam int STATUS_W = 31;
    localparam int LEVEL_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_LOAD    = 2'd1,
        OP_SWEEP   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_TICKS = 1'd1;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET    = 4'd0;
    localparam logic [TICKS_W-1:0] EXPIRE_TICKS_RESET = 16'd30;

    // status word codes; 3 and above is a last-used frame time
    localparam logic [STATUS_W-1:0] ST_NEW        = 31'd0;
    localparam logic [STATUS_W-1:0] ST_LOADING    = 31'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 31'd2;
    localparam logic [STATUS_W-1:0] ST_FIRST_TIME = 31'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [LEVEL_W-1:0]  level;
        logic [STATUS_W-1:0] now_time;
        logic                load_ok;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [LEVEL_W-1:0]  level_out;
        logic                start_load;
        logic [LEVEL_W-1:0]  load_level;
        logic [COUNT_W-1:0]  released_count;
    } result_t;

endpackage

// File: src/mip_level_residency_policy.sv
// ----------------------------------------------------------------------------
// mip_level_residency_policy
// Per-level residency status store with request search, load reports and
// expire sweeps. Status words live in a RAM; per-entry valid bits make a
// never-written or freed entry read as New.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  item    | in        | item_valid/stall   | item   (mlrp_pkg::item_t)
//  result  | out       | result_valid/stall | result (mlrp_pkg::result_t)
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//
//  An item is accepted in the idle state, then visits each level through
//  a RAM read state and an evaluate-and-write-back state, and finishes in
//  the done state; the single RAM read port gives one read per level.
//  Reset clears all valid bits at once, so no clearing pass is needed.
//  A stalled result sits in the output register; the next item is taken
//  meanwhile and waits in the final state only if the register is still full.
// ----------------------------------------------------------------------------
module mip_level_residency_policy #(
    parameter int LEVEL_COUNT = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  mlrp_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mlrp_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mlrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlrp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(LEVEL_COUNT);
    localparam logic [mlrp_pkg::LEVEL_W-1:0] TOP_LIMIT =
        (LEVEL_COUNT > 16) ? 4'd15 : 4'(LEVEL_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [mlrp_pkg::LEVEL_W-1:0]        max_level_reg;
    logic [mlrp_pkg::TICKS_W-1:0]        expire_ticks_reg;
    logic [LEVEL_COUNT-1:0]              valid_reg, valid_next;

    logic [1:0]                          op_reg, op_next;
    logic [mlrp_pkg::LEVEL_W-1:0]        req_reg, req_next;
    logic [mlrp_pkg::LEVEL_W-1:0]        top_reg, top_next;
    logic [mlrp_pkg::STATUS_W-1:0]       now_reg, now_next;
    logic                                ok_reg, ok_next;
    logic [mlrp_pkg::COUNT_W-1:0]        cur_reg, cur_next;
    logic                                down_reg, down_next;
    logic                                vbit_reg, vbit_next;
    mlrp_pkg::result_t                   res_reg, res_next;
    logic                                result_valid_reg, result_valid_next;
    mlrp_pkg::result_t                   result_reg, result_next;

    logic                                ram_we, ram_re;
    logic [mlrp_pkg::STATUS_W-1:0]       ram_wdata, ram_rdata;
    logic [AW-1:0]                       addr;

    logic                                item_xfer;
    logic [mlrp_pkg::LEVEL_W-1:0]        acc_top;
    logic [mlrp_pkg::STATUS_W-1:0]       status;
    logic [mlrp_pkg::STATUS_W:0]         stale_limit;
    logic [mlrp_pkg::COUNT_W-1:0]        req_up;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_xfer    = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign addr         = cur_reg[AW-1:0];
    assign acc_top      = (max_level_reg > TOP_LIMIT) ? TOP_LIMIT : max_level_reg;
    assign status       = vbit_reg ? ram_rdata : mlrp_pkg::ST_NEW;
    assign stale_limit  = {1'b0, status} + 32'(expire_ticks_reg);
    assign req_up       = {1'b0, req_reg} + 5'd1;

    mlrp_ram #(
        .WIDTH (mlrp_pkg::STATUS_W),
        .DEPTH (LEVEL_COUNT)
    ) u_status_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        op_next           = op_reg;
        req_next          = req_reg;
        top_next          = top_reg;
        now_next          = now_reg;
        ok_next           = ok_reg;
        cur_next          = cur_reg;
        down_next         = down_reg;
        vbit_next         = vbit_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_wdata         = now_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    op_next   = item.op;
                    top_next  = acc_top;
                    now_next  = (item.now_time < mlrp_pkg::ST_FIRST_TIME) ?
                                mlrp_pkg::ST_FIRST_TIME : item.now_time;
                    ok_next   = item.load_ok;
                    res_next  = '0;
                    down_next = 1'b1;
                    req_next  = (item.level > acc_top) ? acc_top : item.level;
                    case (item.op)
                        mlrp_pkg::OP_REQUEST:
                        begin
                            cur_next   = {1'b0, (item.level > acc_top) ? acc_top : item.level};
                            state_next = S_READ;
                        end
                        mlrp_pkg::OP_LOAD:
                        begin
                            cur_next   = {1'b0, item.level};
                            state_next = (item.level <= acc_top) ? S_READ : S_DONE;
                        end
                        mlrp_pkg::OP_SWEEP:
                        begin
                            cur_next   = '0;
                            state_next = (acc_top == '0) ? S_DONE : S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                vbit_next  = valid_reg[addr];
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                case (op_reg)
                    mlrp_pkg::OP_REQUEST:
                    begin
                        if (status == now_reg)
                        begin
                            res_next.found     = 1'b1;
                            res_next.level_out = cur_reg[mlrp_pkg::LEVEL_W-1:0];
                        end
                        else if (status == mlrp_pkg::ST_NEW ||
                                 status == mlrp_pkg::ST_LOADING ||
                                 status == mlrp_pkg::ST_ERROR)
                        begin
                            if (status == mlrp_pkg::ST_NEW && cur_reg == {1'b0, req_reg})
                            begin
                                ram_we              = 1'b1;
                                ram_wdata           = mlrp_pkg::ST_LOADING;
                                valid_next[addr]    = 1'b1;
                                res_next.start_load = 1'b1;
                                res_next.load_level = cur_reg[mlrp_pkg::LEVEL_W-1:0];
                            end
                            // move on: downward to 0, then upward past the request
                            if (down_reg)
                            begin
                                if (cur_reg == '0)
                                begin
                                    if (req_up <= {1'b0, top_reg})
                                    begin
                                        cur_next   = req_up;
                                        down_next  = 1'b0;
                                        state_next = S_READ;
                                    end
                                end
                                else
                                begin
                                    cur_next   = cur_reg - 5'd1;
                                    state_next = S_READ;
                                end
                            end
                            else if (cur_reg != {1'b0, top_reg})
                            begin
                                cur_next   = cur_reg + 5'd1;
                                state_next = S_READ;
                            end
                        end
                        else
                        begin
                            ram_we             = 1'b1;
                            ram_wdata          = now_reg;
                            valid_next[addr]   = 1'b1;
                            res_next.found     = 1'b1;
                            res_next.level_out = cur_reg[mlrp_pkg::LEVEL_W-1:0];
                        end
                    end
                    mlrp_pkg::OP_LOAD:
                    begin
                        if (status == mlrp_pkg::ST_NEW || status == mlrp_pkg::ST_LOADING)
                        begin
                            ram_we           = 1'b1;
                            ram_wdata        = ok_reg ? now_reg : mlrp_pkg::ST_ERROR;
                            valid_next[addr] = 1'b1;
                        end
                    end
                    mlrp_pkg::OP_SWEEP:
                    begin
                        if (status >= mlrp_pkg::ST_ERROR &&
                            {1'b0, now_reg} > stale_limit)
                        begin
                            valid_next[addr]        = 1'b0;
                            res_next.released_count = res_reg.released_count + 5'd1;
                        end
                        if (cur_reg + 5'd1 != {1'b0, top_reg})
                        begin
                            cur_next   = cur_reg + 5'd1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_next       = res_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
            max_level_reg    <= mlrp_pkg::MAX_LEVEL_RESET;
            expire_ticks_reg <= mlrp_pkg::EXPIRE_TICKS_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mlrp_pkg::CFG_MAX_LEVEL:
                    begin
                        max_level_reg <= cfg_data[mlrp_pkg::LEVEL_W-1:0];
                    end
                    mlrp_pkg::CFG_EXPIRE_TICKS:
                    begin
                        expire_ticks_reg <= cfg_data;
                    end
                    default:
                    begin
                        max_level_reg <= max_level_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        req_reg    <= req_next;
        top_reg    <= top_next;
        now_reg    <= now_next;
        ok_reg     <= ok_next;
        cur_reg    <= cur_next;
        down_reg   <= down_next;
        vbit_reg   <= vbit_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

`ifndef SYNTH
    // RAM is written only while evaluating a visited level
    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_EVAL)
        else $error("status RAM written outside evaluate state");

    // each read is followed by its evaluation
    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_EVAL)
        else $error("read not followed by evaluate");

    // a request never both loads and returns the same level
    a_load_not_returned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_reg.found && res_reg.start_load) |->
        res_reg.level_out != res_reg.load_level)
        else $error("loaded level also returned");

    // visits stay within the levels in use
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && op_reg != mlrp_pkg::OP_LOAD) |->
        cur_reg <= {1'b0, top_reg})
        else $error("level cursor beyond largest level");

    // freed count never exceeds the number of swept levels
    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && op_reg == mlrp_pkg::OP_SWEEP) |->
        res_reg.released_count <= {1'b0, top_reg})
        else $error("released count exceeds swept levels");
`endif

endmodule

// File: src/mlrp_ram.sv
// ----------------------------------------------------------------------------
// mlrp_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module mlrp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: tb/sv/mip_level_residency_policy_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mip_level_residency_policy_tb
// Self-checking bench for the mip level residency store. A queue-fed driver
// sends requests, load reports and expire sweeps. A shadow copy of the level
// status table predicts each result. A monitor compares every result transfer
// against the oldest prediction. Several register settings are applied
// between drained phases, and sender and receiver idle at varying rates.
// ----------------------------------------------------------------------------
module mip_level_residency_policy_tb;

    localparam int LEVEL_COUNT    = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTING_COUNT  = 6;
    localparam int CHUNK_ITEMS    = 185;
    localparam int TIME_MAX       = 32'h7FFF_FFFF;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            item_valid = 1'b0;
    logic                            item_stall;
    mlrp_pkg::item_t                 item = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    mlrp_pkg::result_t               result;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mlrp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mlrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the block's table and registers
    logic [mlrp_pkg::STATUS_W-1:0] level_status [LEVEL_COUNT];
    logic [mlrp_pkg::LEVEL_W-1:0]  cur_max_level = mlrp_pkg::MAX_LEVEL_RESET;
    logic [mlrp_pkg::TICKS_W-1:0]  cur_expire_ticks = mlrp_pkg::EXPIRE_TICKS_RESET;

    mlrp_pkg::item_t   pending_items[$];
    mlrp_pkg::result_t expected_results[$];
    int                recent_levels[$];
    longint            frame_clock;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    bit                item_moved = 1'b0;

    mip_level_residency_policy #(
        .LEVEL_COUNT(LEVEL_COUNT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // one level of a request search; returns 1 when the level is handed out
    function automatic bit visit_level(int lv, int req,
                                       logic [mlrp_pkg::STATUS_W-1:0] now_t,
                                       inout mlrp_pkg::result_t r);
        logic [mlrp_pkg::STATUS_W-1:0] old;
        old = level_status[lv];
        if (old == now_t)
        begin
            r.found     = 1'b1;
            r.level_out = mlrp_pkg::LEVEL_W'(lv);
            return 1'b1;
        end
        if (old == mlrp_pkg::ST_LOADING || old == mlrp_pkg::ST_ERROR)
            return 1'b0;
        if (old == mlrp_pkg::ST_NEW)
        begin
            if (lv == req)
            begin
                level_status[lv] = mlrp_pkg::ST_LOADING;
                r.start_load     = 1'b1;
                r.load_level     = mlrp_pkg::LEVEL_W'(lv);
            end
            return 1'b0;
        end
        level_status[lv] = now_t;
        r.found          = 1'b1;
        r.level_out      = mlrp_pkg::LEVEL_W'(lv);
        return 1'b1;
    endfunction

    function automatic mlrp_pkg::result_t resolve_item(mlrp_pkg::item_t it);
        mlrp_pkg::result_t             r;
        logic [mlrp_pkg::STATUS_W-1:0] now_t;
        int                            top;
        int                            req;
        int                            lv;
        int                            freed;
        bit                            done;
        r     = '0;
        top   = int'(cur_max_level);
        now_t = (it.now_time < mlrp_pkg::ST_FIRST_TIME) ? mlrp_pkg::ST_FIRST_TIME
                                                        : it.now_time;
        done  = 1'b0;
        freed = 0;
        case (it.op)
            mlrp_pkg::OP_REQUEST:
            begin
                req = (int'(it.level) > top) ? top : int'(it.level);
                // requested level, then finer, then coarser
                for (lv = req; lv >= 0 && !done; lv--)
                    done = visit_level(lv, req, now_t, r);
                for (lv = req + 1; lv <= top && !done; lv++)
                    done = visit_level(lv, req, now_t, r);
            end
            mlrp_pkg::OP_LOAD:
            begin
                if (int'(it.level) <= top &&
                    (level_status[it.level] == mlrp_pkg::ST_NEW ||
                     level_status[it.level] == mlrp_pkg::ST_LOADING))
                    level_status[it.level] = it.load_ok ? now_t : mlrp_pkg::ST_ERROR;
            end
            mlrp_pkg::OP_SWEEP:
            begin
                // last level in use is never freed
                for (lv = 0; lv < top; lv++)
                begin
                    if (level_status[lv] > mlrp_pkg::ST_LOADING &&
                        {2'b00, now_t} > {2'b00, level_status[lv]} + {17'd0, cur_expire_ticks})
                    begin
                        level_status[lv] = mlrp_pkg::ST_NEW;
                        freed++;
                    end
                end
                r.released_count = mlrp_pkg::COUNT_W'(freed);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // driver: a new transfer is presented once the previous one has gone
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_moved))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
        result_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        mlrp_pkg::result_t want;
        item_moved = rst_n && item_valid && !item_stall;
        if (item_moved)
            expected_results.push_back(resolve_item(item));
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none pending", 32'(result), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (result.found !== want.found)
                    report_mismatch("found", 32'(result.found), 32'(want.found));
                if (result.level_out !== want.level_out)
                    report_mismatch("level_out", 32'(result.level_out),
                                    32'(want.level_out));
                if (result.start_load !== want.start_load)
                    report_mismatch("start_load", 32'(result.start_load),
                                    32'(want.start_load));
                if (result.load_level !== want.load_level)
                    report_mismatch("load_level", 32'(result.load_level),
                                    32'(want.load_level));
                if (result.released_count !== want.released_count)
                    report_mismatch("released_count", 32'(result.released_count),
                                    32'(want.released_count));
            end
        end
        if (!rst_n || item_moved || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("mip_level_residency_policy regression: fail");
            $finish;
        end
    end

    function automatic mlrp_pkg::item_t make_item(mlrp_pkg::op_t op, int lv, int now_i, bit ok);
        mlrp_pkg::item_t it;
        it.op       = op;
        it.level    = mlrp_pkg::LEVEL_W'(lv);
        it.now_time = mlrp_pkg::STATUS_W'(now_i);
        it.load_ok  = ok;
        return it;
    endfunction

    task automatic write_reg(logic [mlrp_pkg::CFG_IDX_W-1:0] idx,
                             logic [mlrp_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == mlrp_pkg::CFG_MAX_LEVEL)
            cur_max_level = value[mlrp_pkg::LEVEL_W-1:0];
        else
            cur_expire_ticks = value[mlrp_pkg::TICKS_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(int max_lv, int ticks);
        write_reg(mlrp_pkg::CFG_MAX_LEVEL, mlrp_pkg::CFG_DATA_W'(max_lv));
        write_reg(mlrp_pkg::CFG_EXPIRE_TICKS, mlrp_pkg::CFG_DATA_W'(ticks));
    endtask

    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    endtask

    // mostly a slowly advancing frame clock so hits, restamps and staleness
    // all occur; now and then a jump, a full-range time or a time below codes
    task automatic queue_random_items(int count);
        int            k;
        int            pick;
        int            lv;
        int            now_i;
        mlrp_pkg::op_t op;
        bit            ok;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                frame_clock += $urandom_range(0, 70000);
            else if (pick < 6)
                frame_clock = longint'($urandom_range(0, 32'h7FFF_FFFF));
            else
                frame_clock += $urandom_range(0, 2);
            if (frame_clock > 64'h7FFF_FFFF - 80000)
                frame_clock = $urandom_range(0, 40);
            now_i = ($urandom_range(0, 99) < 3) ? int'($urandom_range(0, 2))
                                                : int'(frame_clock);

            pick = $urandom_range(0, 99);
            op   = (pick < 45) ? mlrp_pkg::OP_REQUEST : (pick < 80) ? mlrp_pkg::OP_LOAD :
                   (pick < 95) ? mlrp_pkg::OP_SWEEP : mlrp_pkg::OP_NONE;
            pick = $urandom_range(0, 99);
            if (op == mlrp_pkg::OP_LOAD && recent_levels.size() != 0 && pick < 75)
                lv = recent_levels[$urandom_range(0, recent_levels.size() - 1)];
            else if (pick < 85)
                lv = $urandom_range(0, int'(cur_max_level));
            else
                lv = $urandom_range(0, LEVEL_COUNT - 1);
            ok = (op == mlrp_pkg::OP_LOAD) ? ($urandom_range(0, 99) < 80) : 1'($urandom);
            if (op == mlrp_pkg::OP_REQUEST)
            begin
                recent_levels.push_back(lv);
                if (recent_levels.size() > 4)
                    void'(recent_levels.pop_front());
            end
            pending_items.push_back(make_item(op, lv, now_i, ok));
        end
    endtask

    initial
    begin
        int setting_max   [SETTING_COUNT];
        int setting_ticks [SETTING_COUNT];
        int s;
        setting_max   = '{15, 0, 7, 15, 4, 15};
        setting_ticks = '{30, 0, 65535, 3, 200, 0};
        for (s = 0; s < LEVEL_COUNT; s++)
            level_status[s] = mlrp_pkg::ST_NEW;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 76;

        // directed: loads, hits, restamps, errors, clamping, sweeps
        apply_setting(15, 10);
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 15, 0, 1'b0));  // time raised
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 15, 5, 1'b1));
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 15, 5, 1'b0));  // hit, same time
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 12, 6, 1'b0));  // load and found
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 12, 6, 1'b0));     // load failed
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 12, 6, 1'b1));     // error: ignored
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 12, 7, 1'b0));
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 3, 8, 1'b0));
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 3, 8, 1'b0));   // loading skipped
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 3, 9, 1'b1));
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 3, 9, 1'b0));      // resident
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 0, TIME_MAX, 1'b1));
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 0, TIME_MAX, 1'b0));
        pending_items.push_back(make_item(mlrp_pkg::OP_SWEEP, 0, 100, 1'b0));   // frees errors
        pending_items.push_back(make_item(mlrp_pkg::OP_NONE, 15, 50, 1'b1));
        wait_for_drain();

        apply_setting(2, 65535);
        pending_items.push_back(make_item(mlrp_pkg::OP_LOAD, 9, 20, 1'b1));     // beyond top
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 9, 20, 1'b0));  // clamped to 2
        pending_items.push_back(make_item(mlrp_pkg::OP_REQUEST, 1, 2, 1'b0));
        pending_items.push_back(make_item(mlrp_pkg::OP_SWEEP, 0, TIME_MAX, 1'b0));
        pending_items.push_back(make_item(mlrp_pkg::OP_SWEEP, 15, 70000, 1'b1));
        wait_for_drain();

        frame_clock = 3;
        for (s = 0; s < SETTING_COUNT; s++)
        begin
            if (s == 2)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 18;
            end
            else if (s == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(setting_max[s], setting_ticks[s]);
            queue_random_items(CHUNK_ITEMS);
            wait_for_drain();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("mip_level_residency_policy regression: pass");
        else
            $display("mip_level_residency_policy regression: fail");
        $finish;
    end

endmodule

// File: sim.f
src/mlrp_pkg.sv
src/mlrp_ram.sv
src/mip_level_residency_policy.sv
tb/sv/mip_level_residency_policy_tb.sv
